/* sv/bcpe_pkg.sv */
// Shared types and constants for the Bezier curve point evaluator.
// No dependencies.
package bcpe_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int T_W     = 17;
  localparam int SEG_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + T_W + 1;

  localparam logic [SEG_W-1:0] SEG_COUNT_RESET = 16'd100;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
  } cell_ctl_t;

endpackage

/* sv/bcpe_cell.sv */
// One cell of the interpolation chain: holds a control point and a work point.
// Depends on bcpe_pkg.
module bcpe_cell
  import bcpe_pkg::*;
(
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic                       wr,
  input  logic signed [COORD_W-1:0]  wr_x,
  input  logic signed [COORD_W-1:0]  wr_y,
  input  logic        [T_W-1:0]      t,
  input  logic signed [COORD_W-1:0]  nb_x,
  input  logic signed [COORD_W-1:0]  nb_y,
  output logic signed [COORD_W-1:0]  work_x,
  output logic signed [COORD_W-1:0]  work_y
);

  logic signed [COORD_W-1:0] ctrl_x;
  logic signed [COORD_W-1:0] ctrl_y;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [DIFF_W-1:0]  diff_x;
  logic signed [DIFF_W-1:0]  diff_y;
  logic signed [T_W:0]       t_s;
  logic signed [PROD_W-1:0]  sum_x;
  logic signed [PROD_W-1:0]  sum_y;

  assign t_s    = $signed({1'b0, t});
  assign diff_x = DIFF_W'(nb_x) - DIFF_W'(work_x);
  assign diff_y = DIFF_W'(nb_y) - DIFF_W'(work_y);
  assign sum_x  = prod_x + $signed(ROUND_HALF);
  assign sum_y  = prod_y + $signed(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (wr) begin
      ctrl_x <= wr_x;
      ctrl_y <= wr_y;
    end
    if (ctl.mul) begin
      prod_x <= PROD_W'(diff_x) * PROD_W'(t_s);
      prod_y <= PROD_W'(diff_y) * PROD_W'(t_s);
    end
    if (ctl.load) begin
      work_x <= ctrl_x;
      work_y <= ctrl_y;
    end else if (ctl.upd) begin
      // floor of (prod + half) / 2^16 added to a
      work_x <= work_x + $signed(sum_x[FRAC_W+COORD_W-1:FRAC_W]);
      work_y <= work_y + $signed(sum_y[FRAC_W+COORD_W-1:FRAC_W]);
    end
  end

endmodule

/* sv/bcpe_tdiv.sv */
// Bit-serial divider forming t = round(idx * 2^16 / segs), half up, in Q1.16.
// Depends on bcpe_pkg.
module bcpe_tdiv
  import bcpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SEG_W-1:0] idx,
  input  logic [SEG_W-1:0] segs,
  output logic             done,
  output logic [T_W-1:0]   t
);

  localparam int Q_W     = T_W + 1;
  localparam int STEPS   = T_W;
  localparam int STEP_W  = $clog2(STEPS + 1);

  logic [SEG_W-1:0]  divisor;
  logic [SEG_W-1:0]  rem;
  logic [Q_W-1:0]    q;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [SEG_W:0]    rem2;
  logic              ge;
  logic [Q_W:0]      q_inc;

  assign rem2  = {rem, 1'b0};
  assign ge    = rem2 >= {1'b0, divisor};
  assign q_inc = (Q_W+1)'(q) + (Q_W+1)'(1);
  assign t     = T_W'(q_inc >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= segs;
      if (idx >= segs) begin
        rem <= idx - segs;
        q   <= Q_W'(1);
      end else begin
        rem <= idx;
        q   <= '0;
      end
    end else if (busy) begin
      rem <= ge ? SEG_W'(rem2 - {1'b0, divisor}) : rem2[SEG_W-1:0];
      q   <= {q[Q_W-2:0], ge};
    end
  end

endmodule

/* sv/bezier_curve_point_eval_unit.sv */
// Bezier curve point evaluator, de Casteljau over a chain of lerp cells.
// A load is taken in the idle state and writes one control point. An evaluate with n >= 2 points
// passes through the transfer, the bit-serial t divider, the n - 1 interpolation rounds (each a
// multiply step and an update step) and writeback; a stalled output holds it in writeback.
// With fewer than two points it goes straight to writeback. One item is worked at a time.
// Synchronous reset clears the point count, segment_count (to 100) and the handshakes.
module bezier_curve_point_eval_unit
  import bcpe_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [SLOT_W-1:0]         point_index,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [SEG_W-1:0]          sample_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] curve_x,
  output logic signed [COORD_W-1:0] curve_y,
  output logic                      no_curve
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LERP = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  localparam logic REG_SEGMENT_COUNT = 1'b0;

  logic [1:0]       state;
  logic             phase;
  logic [CNT_W-1:0] rounds;
  logic [CNT_W-1:0] point_count;
  logic [SEG_W-1:0] segment_count;
  logic             nocurve_r;

  logic             in_acc;
  logic             load_acc;
  logic             eval_acc;
  logic             wb_fire;
  logic [CNT_W-1:0] n_eff;
  logic [SEG_W-1:0] segs;
  logic [SEG_W-1:0] idx_sat;
  logic             div_start;
  logic             div_done;
  logic [T_W-1:0]   t;
  cell_ctl_t        ctl;

  logic signed [COORD_W-1:0] work_x [MAX_POINTS];
  logic signed [COORD_W-1:0] work_y [MAX_POINTS];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? {16'b0, segment_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEGMENT_COUNT) begin
      segment_count <= pwdata[SEG_W-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && req_type == REQ_LOAD;
  assign eval_acc = in_acc && req_type == REQ_EVAL;

  always_comb begin
    if (int'(point_count) > MAX_POINTS) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  assign segs    = (segment_count != '0) ? segment_count
                 : SEG_W'({n_eff, 3'b000}) + SEG_W'({n_eff, 1'b0});
  assign idx_sat = (sample_index > segs) ? segs : sample_index;

  assign div_start = eval_acc && n_eff >= CNT_W'(2);
  assign wb_fire   = (state == S_WB) && (!out_valid || !out_stall);

  assign ctl.load = div_start;
  assign ctl.mul  = (state == S_LERP) && !phase;
  assign ctl.upd  = (state == S_LERP) && phase;

  bcpe_tdiv u_tdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .idx   (idx_sat),
    .segs  (segs),
    .done  (div_done),
    .t     (t)
  );

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic signed [COORD_W-1:0] nb_x;
    logic signed [COORD_W-1:0] nb_y;
    logic                      wr;

    if (k == MAX_POINTS - 1) begin : g_last
      assign nb_x = '0;
      assign nb_y = '0;
    end else begin : g_mid
      assign nb_x = work_x[k+1];
      assign nb_y = work_y[k+1];
    end

    assign wr = load_acc && (int'(point_index) == k);

    bcpe_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr     (wr),
      .wr_x   (point_x),
      .wr_y   (point_y),
      .t      (t),
      .nb_x   (nb_x),
      .nb_y   (nb_y),
      .work_x (work_x[k]),
      .work_y (work_y[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= 1'b0;
      rounds      <= '0;
      point_count <= '0;
      nocurve_r   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load_acc && int'(point_index) < MAX_POINTS) begin
            point_count <= CNT_W'(point_index) + CNT_W'(1);
          end
          if (div_start) begin
            nocurve_r <= 1'b0;
            rounds    <= n_eff - CNT_W'(1);
            state     <= S_DIV;
          end else if (eval_acc) begin
            nocurve_r <= 1'b1;
            state     <= S_WB;
          end
        end
        S_DIV: begin
          phase <= 1'b0;
          if (div_done) begin
            state <= S_LERP;
          end
        end
        S_LERP: begin
          phase <= !phase;
          if (phase) begin
            rounds <= rounds - CNT_W'(1);
            if (rounds == CNT_W'(1)) begin
              state <= S_WB;
            end
          end
        end
        S_WB: begin
          if (wb_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      curve_x  <= nocurve_r ? '0 : work_x[0];
      curve_y  <= nocurve_r ? '0 : work_y[0];
      no_curve <= nocurve_r;
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking testbench for bezier_curve_point_eval_unit: a directed table, then
// random load/evaluate traffic under several segment counts, checked by a de Casteljau predictor.
// Depends on bcpe_pkg and the bezier_curve_point_eval_unit RTL.
module tb;
  import bcpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam logic [2:0] SEG_COUNT_ADDR = 3'd0;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               nc;
  } curve_pt_t;

  typedef struct packed {
    logic        req;
    logic [3:0]  slot;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] smp;
    logic        fixed;
    logic [31:0] ex;
    logic [31:0] ey;
    logic        enc;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [3:0]  point_index = '0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [15:0] sample_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] curve_x;
  logic [31:0] curve_y;
  logic        no_curve;

  // predictor state
  longint      pts_x[MAX_PTS];
  longint      pts_y[MAX_PTS];
  int          npts = 0;
  logic [15:0] seg_cnt = SEG_COUNT_RESET;
  logic [15:0] slot_seen = '0;

  curve_pt_t   curve_q[$];
  int          fails = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          steady_send = 1'b0;

  int          hold_left = 0;
  int          burst_left = 0;
  int          mode_left = 0;
  int          rx_mode = 0;

  stim_row_t dir_rows[19] = '{
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd0, 1'b1, 32'h0, 32'h0, 1'b1},
    '{REQ_LOAD, 4'd0, CMIN, CMAX, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd9, 32'h0, 32'h0, 16'hffff, 1'b1, 32'h0, 32'h0, 1'b1},
    '{REQ_LOAD, 4'd1, CMAX, CMIN, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd0, 1'b1, CMIN, CMAX, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd100, 1'b1, CMAX, CMIN, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'hffff, 1'b1, CMAX, CMIN, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd50, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd1, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_LOAD, 4'd2, 32'h0, 32'h0, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_LOAD, 4'd3, 32'hffff_ffff, 32'h1, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd33, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd99, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_LOAD, 4'd1, 32'h0001_0000, 32'hffff_0000, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd50, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_LOAD, 4'd0, 32'h5555_5555, 32'haaaa_aaaa, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd0, 32'h0, 32'h0, 16'd0, 1'b1, 32'h0, 32'h0, 1'b1},
    '{REQ_LOAD, 4'd0, 32'h0, 32'h0, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_EVAL, 4'd15, CMAX, CMIN, 16'd7, 1'b1, 32'h0, 32'h0, 1'b1}
  };

  int seg_plan[7] = '{0, 1, 65535, 2, -1, 0, 100};

  bezier_curve_point_eval_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .sample_index(sample_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .curve_x(curve_x), .curve_y(curve_y), .no_curve(no_curve)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    longint s;
    s = a * (65536 - t) + b * t + 32768;
    return s >>> 16;
  endfunction

  function automatic curve_pt_t bezier_sample(input logic [15:0] smp);
    curve_pt_t r;
    longint wx[MAX_PTS];
    longint wy[MAX_PTS];
    longint segs;
    longint idx;
    longint t;
    r = '0;
    if (npts < 2) begin
      r.nc = 1'b1;
      return r;
    end
    segs = (seg_cnt != 0) ? longint'(seg_cnt) : longint'(10 * npts);
    idx = smp;
    if (idx > segs) idx = segs;
    t = (idx * 131072 + segs) / (2 * segs);
    for (int k = 0; k < MAX_PTS; k++) begin
      wx[k] = pts_x[k];
      wy[k] = pts_y[k];
    end
    for (int j = 1; j < npts; j++) begin
      for (int k = 0; k + j < npts; k++) begin
        wx[k] = lerp_q16(wx[k], wx[k + 1], t);
        wy[k] = lerp_q16(wy[k], wy[k + 1], t);
      end
    end
    r.x = 32'(wx[0]);
    r.y = 32'(wy[0]);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CMIN;
    if (r == 1) return CMAX;
    if (r == 2) return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
    return $urandom;
  endfunction

  task automatic add_expected(input curve_pt_t res);
    curve_q = {curve_q, res};
  endtask

  task automatic send_req(input logic req, input logic [3:0] slot, input logic [31:0] px,
                          input logic [31:0] py, input logic [15:0] smp, input bit fixed,
                          input curve_pt_t fixed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    point_index  <= slot;
    point_x      <= px;
    point_y      <= py;
    sample_index <= smp;
    do @(posedge clk); while (in_stall);
    if (req == REQ_LOAD) begin
      pts_x[slot] = longint'($signed(px));
      pts_y[slot] = longint'($signed(py));
      npts = slot + 1;
      slot_seen[slot] = 1'b1;
    end else if (fixed) begin
      add_expected(fixed_res);
    end else begin
      add_expected(bezier_sample(smp));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_seg_count(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEG_COUNT_ADDR;
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seg_cnt = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== v) begin
      fails++;
      $display("%0t: segment_count readback expected %0d actual %0d", $time, v, prdata[15:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random();
    int r;
    int top;
    int segs_eff;
    logic [3:0] slot;
    logic [15:0] smp;
    top = 0;
    while (top < MAX_PTS - 1 && slot_seen[top]) top++;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      r = $urandom_range(0, 99);
      if (r < 45) slot = 4'((npts < MAX_PTS - 1) ? npts : MAX_PTS - 1);
      else if (r < 60) slot = 4'(top);
      else slot = 4'($urandom_range(0, top));
      send_req(REQ_LOAD, slot, rand_coord(), rand_coord(), 16'($urandom), 1'b0, '0);
    end else begin
      segs_eff = (seg_cnt != 0) ? int'(seg_cnt) : 10 * npts;
      r = $urandom_range(0, 99);
      if (r < 50) smp = 16'($urandom_range(0, segs_eff));
      else if (r < 60) smp = 16'(segs_eff);
      else if (r < 70) smp = '0;
      else if (r < 80) smp = 16'hffff;
      else smp = 16'($urandom);
      send_req(REQ_EVAL, 4'($urandom), $urandom, $urandom, smp, 1'b0, '0);
    end
  endtask

  // result check and receiver stall
  always @(posedge clk) begin : rx_side
    curve_pt_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (curve_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected transfer x=%h y=%h no_curve=%b", $time,
                   curve_x, curve_y, no_curve);
        end else begin
          want = curve_q.pop_front();
          if (curve_x !== want.x) begin
            fails++;
            $display("%0t: curve_x expected %h actual %h", $time, want.x, curve_x);
          end
          if (curve_y !== want.y) begin
            fails++;
            $display("%0t: curve_y expected %h actual %h", $time, want.y, curve_y);
          end
          if (no_curve !== want.nc) begin
            fails++;
            $display("%0t: no_curve expected %b actual %b", $time, want.nc, no_curve);
          end
        end
        if (results_seen == 40 || results_seen == 600) hold_left = 400;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: begin
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
            out_stall <= 1'b0;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bezier_curve_point_eval_unit verification failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < MAX_PTS; k++) begin
      pts_x[k] = 0;
      pts_y[k] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].slot, dir_rows[i].px, dir_rows[i].py,
               dir_rows[i].smp, dir_rows[i].fixed,
               '{x: dir_rows[i].ex, y: dir_rows[i].ey, nc: dir_rows[i].enc});
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      if (seg_plan[p] < 0) write_seg_count(16'($urandom_range(3, 400)));
      else write_seg_count(16'(seg_plan[p]));
      steady_send = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random();
        if (p == 1 && i == 120) drain();
      end
    end

    drain();
    if (fails == 0) begin
      $display("bezier_curve_point_eval_unit verification clean");
    end else begin
      $display("bezier_curve_point_eval_unit verification failed");
    end
    $finish;
  end

endmodule
